/* rtl/jmsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsc_pkg
// Shared types and constants for the JPEG marker structure checker.
// ----------------------------------------------------------------------------
package jmsc_pkg;

  // marker and stuffing byte values
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] BYTE_SOS = 8'hDA;
  localparam logic [7:0] BYTE_RST = 8'hD0;
  localparam logic [7:0] BYTE_00  = 8'h00;

  // config register address (word index)
  localparam logic ADDR_FAST_ACCEPT = 1'b0;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_SOI_A  = 7'b0000001,
    PH_SOI_B  = 7'b0000010,
    PH_MARK   = 7'b0000100,
    PH_LEN_HI = 7'b0001000,
    PH_LEN_LO = 7'b0010000,
    PH_SKIP   = 7'b0100000,
    PH_DRAIN  = 7'b1000000
  } phase_t;

  // verdict codes
  typedef enum logic [2:0] {
    V_EOI     = 3'd0,
    V_FAST    = 3'd1,
    V_NO_SOI  = 3'd2,
    V_STRAY   = 3'd3,
    V_TRUNC   = 3'd4,
    V_BAD_LEN = 3'd5
  } verdict_t;

  // parser state carried from item to item
  typedef struct packed {
    phase_t      phase;
    logic        held_valid;
    logic        scan_active;
    logic        segment_is_sos;
    logic [7:0]  length_high;
    logic [15:0] skip_remaining;
  } parse_state_t;

  // result of one step
  typedef struct packed {
    logic     valid;
    verdict_t code;
  } step_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_SOI_A,
    held_valid:     1'b0,
    scan_active:    1'b0,
    segment_is_sos: 1'b0,
    length_high:    8'h00,
    skip_remaining: 16'h0000
  };

endpackage

/* rtl/jmsc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsc_cfg
// APB-style register port holding the fast_accept control bit.
// ----------------------------------------------------------------------------
module jmsc_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        fast_accept
);

  logic wr_en;
  logic hit;

  // decode
  assign pready = 1'b1;
  assign hit    = (paddr[2] == jmsc_pkg::ADDR_FAST_ACCEPT);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  // register
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_accept <= 1'b0;
    end else if (wr_en) begin
      fast_accept <= pwdata[0];
    end
  end

  // read back
  assign prdata = hit ? {31'b0, fast_accept} : 32'b0;

endmodule

/* rtl/jmsc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsc_step
// Next-state and verdict logic for one byte of the stream.
// ----------------------------------------------------------------------------
module jmsc_step (
  input  jmsc_pkg::parse_state_t st,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  logic                   fast_accept,
  output jmsc_pkg::parse_state_t st_next,
  output jmsc_pkg::step_result_t res
);

  logic        seg_done;
  logic        was_drain;
  logic [15:0] size;
  logic [15:0] rem_dec;
  logic        is_ff;
  logic        is_rst_sa;

  assign is_ff     = (data_byte == jmsc_pkg::BYTE_FF);
  assign size      = {st.length_high, data_byte};
  assign rem_dec   = (st.skip_remaining != 16'd0) ? (st.skip_remaining - 16'd1) : 16'd0;
  // standalone markers D0..D8 carry no length
  assign is_rst_sa = (data_byte >= jmsc_pkg::BYTE_RST) && (data_byte < jmsc_pkg::BYTE_EOI);

  always_comb begin
    st_next   = st;
    res.valid = 1'b0;
    res.code  = jmsc_pkg::V_EOI;
    seg_done  = 1'b0;
    was_drain = 1'b0;

    // per-phase byte handling
    unique case (st.phase)
      jmsc_pkg::PH_SOI_A: begin
        if (is_ff) st_next.phase = jmsc_pkg::PH_SOI_B;
        else begin
          res.valid = 1'b1;
          res.code  = jmsc_pkg::V_NO_SOI;
        end
      end
      jmsc_pkg::PH_SOI_B: begin
        if (data_byte == jmsc_pkg::BYTE_SOI) begin
          st_next.phase      = jmsc_pkg::PH_MARK;
          st_next.held_valid = 1'b0;
        end else begin
          res.valid = 1'b1;
          res.code  = jmsc_pkg::V_NO_SOI;
        end
      end
      jmsc_pkg::PH_MARK: begin
        if (!st.held_valid) begin
          if (is_ff) st_next.held_valid = 1'b1;
          else if (!st.scan_active) begin
            res.valid = 1'b1;
            res.code  = jmsc_pkg::V_STRAY;
          end
        end else if (is_ff) begin
          // fill byte, window slides
        end else if (data_byte == jmsc_pkg::BYTE_EOI) begin
          res.valid = 1'b1;
          res.code  = jmsc_pkg::V_EOI;
        end else if ((st.scan_active && data_byte == jmsc_pkg::BYTE_00) || is_rst_sa) begin
          st_next.held_valid = 1'b0;
        end else begin
          st_next.held_valid     = 1'b0;
          st_next.segment_is_sos = (data_byte == jmsc_pkg::BYTE_SOS);
          st_next.phase          = jmsc_pkg::PH_LEN_HI;
        end
      end
      jmsc_pkg::PH_LEN_HI: begin
        st_next.length_high = data_byte;
        st_next.phase       = jmsc_pkg::PH_LEN_LO;
      end
      jmsc_pkg::PH_LEN_LO: begin
        if (size < 16'd2) begin
          res.valid = 1'b1;
          res.code  = jmsc_pkg::V_BAD_LEN;
        end else begin
          st_next.skip_remaining = size - 16'd2;
          if (size == 16'd2) seg_done = 1'b1;
          else st_next.phase = jmsc_pkg::PH_SKIP;
        end
      end
      jmsc_pkg::PH_SKIP: begin
        st_next.skip_remaining = rem_dec;
        if (rem_dec == 16'd0) seg_done = 1'b1;
      end
      default: begin
        was_drain = 1'b1;
      end
    endcase

    // segment fully skipped
    if (seg_done) begin
      st_next.phase      = jmsc_pkg::PH_MARK;
      st_next.held_valid = 1'b0;
      if (st.segment_is_sos) begin
        st_next.segment_is_sos = 1'b0;
        if (fast_accept) begin
          res.valid = 1'b1;
          res.code  = jmsc_pkg::V_FAST;
        end else begin
          st_next.scan_active = 1'b1;
        end
      end
    end

    // end of stream without a verdict
    if (!res.valid && last_byte && !was_drain) begin
      res.valid = 1'b1;
      res.code  = jmsc_pkg::V_TRUNC;
    end

    // restart or drain
    if (last_byte) st_next = jmsc_pkg::STATE_RESET;
    else if (res.valid) st_next.phase = jmsc_pkg::PH_DRAIN;
  end

endmodule

/* rtl/jpeg_marker_structure_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_marker_structure_check
// Checks a byte stream for JPEG marker structure and gives one verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the input channel (data_byte, last_byte) under
//   in_valid/in_ready, one item per byte; last_byte marks the end of a stream.
//   Each stream yields exactly one verdict item (is_jpeg, verdict_code) on the
//   output channel under out_valid/out_ready, on EOI, on a failure, on a fast
//   accept at SOS, or on the final byte.
//   A verdict is registered in the result register after the byte that causes
//   it has been taken into the input register (input register, then result register).
//   Throughput: one byte per cycle; the per-byte compare and the 16-bit skip
//   counter update fit between the input register and the result register.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only while both are occupied.
//   Reset (rst, synchronous) empties both registers, returns the parser to
//   expect SOI and clears fast_accept. The user must write fast_accept (APB,
//   address 0) only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module jpeg_marker_structure_check (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // verdict output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_jpeg,
  output logic [2:0]  verdict_code,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                   fast_accept;
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   s1_last;
  logic                   advance;
  jmsc_pkg::parse_state_t st;
  jmsc_pkg::parse_state_t st_next;
  jmsc_pkg::step_result_t res;

  // config register
  jmsc_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fast_accept (fast_accept)
  );

  // byte step logic
  jmsc_step u_step (
    .st          (st),
    .data_byte   (s1_byte),
    .last_byte   (s1_last),
    .fast_accept (fast_accept),
    .st_next     (st_next),
    .res         (res)
  );

  // handshake
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= jmsc_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && res.valid;
      if (s1_valid) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && res.valid) begin
      verdict_code <= res.code;
      is_jpeg      <= (res.code == jmsc_pkg::V_EOI) || (res.code == jmsc_pkg::V_FAST);
    end
  end

  // checks
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (st.phase == jmsc_pkg::PH_SOI_A) && !out_valid && !s1_valid)
    else $error("state not cleared after reset");

  a_is_jpeg_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_jpeg == ((verdict_code == jmsc_pkg::V_EOI) ||
                               (verdict_code == jmsc_pkg::V_FAST))))
    else $error("is_jpeg disagrees with verdict_code");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict_code <= jmsc_pkg::V_BAD_LEN))
    else $error("verdict_code out of range");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (st.phase == jmsc_pkg::PH_SKIP) |-> (st.skip_remaining != 16'd0))
    else $error("skip phase with empty skip count");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("parser state changed while result stalled");

endmodule
